// ===== rtl/mppd_pkg.sv =====
package mppd_pkg;

  localparam int GAIN_W     = 32;
  localparam int ANGLE_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int ERR_W      = 25;
  localparam int DRV_W      = 62;
  localparam int DUTY_W     = 7;
  localparam int DRIVE_FRAC = 23;
  localparam int RECIP_SH   = 40;
  localparam int DEG_PER_REV = 360;

  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SH) / 64'd360;
  localparam logic [31:0] RECIP_360  = RECIP_FULL[31:0];

  localparam logic signed [ERR_W-1:0] ZERO_Q7     = ERR_W'(30000 * 128);
  localparam logic signed [ERR_W-1:0] DEADBAND_Q7 = ERR_W'(70 * 128);

  localparam logic [DUTY_W-1:0] DUTY_STOP = DUTY_W'(55);
  localparam logic [DUTY_W-1:0] DUTY_MAX  = DUTY_W'(95);
  localparam logic [DUTY_W-1:0] DUTY_SPAN = DUTY_W'(40);

  typedef enum logic [1:0] {
    DIR_CW   = 2'd0,
    DIR_CCW  = 2'd1,
    DIR_STOP = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_idx_t;

endpackage

// ===== rtl/motor_position_pid_deadband_top.sv =====
// Position PID controller with a deadband, one transaction per sampling tick.
// Input stream (s_axis_*): target angle and encoder count. Output stream
// (m_axis_*): PWM duty, direction and the encoder reset flag.
// Configuration: write kp, ki and kd gains through cfg_wr_en / cfg_addr /
// cfg_wdata while no transaction is in flight; addresses beyond kd are ignored.
// Throughput: one transaction per cycle while the receiver does not stall,
// through a seven-stage pipeline (input register, scale multiply, reciprocal
// multiply for the divide by 360, error, gain multiplies with error history
// update, sum, duty and output).
// The error history advances in the gain multiply stage, in input order.
// Reset clears the gains, the error history and all stage valid bits; the
// output stream then shows no transaction.
// When the receiver stalls, the result holds on m_axis and the pipeline keeps
// accepting input until every stage holds a transaction; s_axis_tready then
// drops until the output is taken.
module motor_position_pid_deadband_top
  import mppd_pkg::*;
#(
  parameter int COUNTS_PER_REV = 11880
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // target_angle[15:0], encoder_count[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // duty[6:0], direction[8:7], encoder_reset[9]
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int CPR_W = $clog2(COUNTS_PER_REV + 1);
  localparam int M_W   = ANGLE_W + CPR_W;
  localparam int Q_W   = M_W - 8;

  logic signed [GAIN_W-1:0] kp_gain;
  logic signed [GAIN_W-1:0] ki_gain;
  logic signed [GAIN_W-1:0] kd_gain;

  logic [7:1] vld;
  logic [7:1] rdy;

  logic signed [ANGLE_W-1:0] ang1;
  logic [COUNT_W-1:0]        cnt1;

  logic [M_W-1:0]      m2;
  logic                neg2;
  logic [COUNT_W-1:0]  cnt2;

  logic [M_W-1:0]      m3;
  logic [Q_W-1:0]      q_est3;
  logic                neg3;
  logic [COUNT_W-1:0]  cnt3;

  logic signed [ERR_W-1:0] e4;

  logic signed [ERR_W-1:0] prev_error;
  logic signed [ERR_W-1:0] prev_prev_error;

  logic signed [56:0] p_term5;
  logic signed [57:0] i_term5;
  logic signed [58:0] d_term5;
  dir_t               dir5;

  logic signed [DRV_W-1:0] drive6;
  dir_t                    dir6;

  logic [DUTY_W-1:0] duty7;
  dir_t              dir7;
  logic              enc_rst7;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= '0;
      ki_gain <= '0;
      kd_gain <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KP:  kp_gain <= cfg_wdata;
        REG_KI:  ki_gain <= cfg_wdata;
        REG_KD:  kd_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[7] = !vld[7] || m_axis_tready;
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= s_axis_tvalid;
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ang1 <= s_axis_tdata[15:0];
      cnt1 <= s_axis_tdata[31:16];
    end
  end

  logic [ANGLE_W-1:0] ang_mag;
  assign ang_mag = ang1[ANGLE_W-1] ? ANGLE_W'(-ang1) : ANGLE_W'(ang1);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      m2   <= M_W'(ang_mag) * M_W'(COUNTS_PER_REV);
      neg2 <= ang1[ANGLE_W-1];
      cnt2 <= cnt1;
    end
  end

  logic [M_W+31:0] recip_prod;
  assign recip_prod = (M_W+32)'(m2) * (M_W+32)'(RECIP_360);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      m3     <= m2;
      q_est3 <= recip_prod[M_W+31:RECIP_SH];
      neg3   <= neg2;
      cnt3   <= cnt2;
    end
  end

  logic [M_W-1:0]          qx360;
  logic [M_W-1:0]          rem3;
  logic [Q_W-1:0]          q3;
  logic signed [ERR_W-1:0] q_ext;
  logic signed [ERR_W-1:0] tgt3;
  logic signed [ERR_W-1:0] cnt_q7;
  logic signed [ERR_W-1:0] e_next;

  always_comb begin
    qx360  = M_W'(q_est3) * M_W'(DEG_PER_REV);
    rem3   = m3 - qx360;
    q3     = q_est3 + Q_W'(rem3 >= M_W'(DEG_PER_REV));
    q_ext  = ERR_W'(q3);
    tgt3   = neg3 ? -q_ext : q_ext;
    cnt_q7 = {2'b00, cnt3, 7'b0000000};
    e_next = tgt3 + ZERO_Q7 - cnt_q7;
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) e4 <= e_next;
  end

  logic signed [ERR_W:0]   sum5;
  logic signed [ERR_W+1:0] dif5;
  logic                    adv5;
  dir_t                    dir_next;

  assign adv5 = rdy[5] && vld[4];

  always_comb begin
    sum5 = (ERR_W+1)'(e4) + (ERR_W+1)'(prev_error);
    dif5 = (ERR_W+2)'(e4) - ((ERR_W+2)'(prev_error) <<< 1) + (ERR_W+2)'(prev_prev_error);
    if (e4 > DEADBAND_Q7) begin
      dir_next = DIR_CW;
    end else if (e4 < -DEADBAND_Q7) begin
      dir_next = DIR_CCW;
    end else begin
      dir_next = DIR_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error      <= '0;
      prev_prev_error <= '0;
    end else if (adv5) begin
      prev_error      <= e4;
      prev_prev_error <= prev_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p_term5 <= kp_gain * e4;
      i_term5 <= ki_gain * sum5;
      d_term5 <= kd_gain * dif5;
      dir5    <= dir_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      drive6 <= DRV_W'(p_term5) + DRV_W'(i_term5) + DRV_W'(d_term5);
      dir6   <= dir5;
    end
  end

  logic signed [DRV_W-1:0] mag6;
  logic [DRV_W-DRIVE_FRAC-1:0] int6;
  logic [DUTY_W-1:0] duty_next;

  always_comb begin
    mag6 = (dir6 == DIR_CW) ? drive6 : -drive6;
    int6 = mag6[DRV_W-1:DRIVE_FRAC];
    if (dir6 == DIR_STOP || mag6 <= 0) begin
      duty_next = DUTY_STOP;
    end else if (int6 >= (DRV_W-DRIVE_FRAC)'(DUTY_SPAN)) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = DUTY_STOP + int6[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      duty7    <= duty_next;
      dir7     <= dir6;
      enc_rst7 <= (dir6 == DIR_STOP);
    end
  end

  assign m_axis_tvalid = vld[7];
  assign m_axis_tdata  = {6'b000000, enc_rst7, dir7, duty7};

`ifndef SYNTHESIS
  a_stop_duty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (dir7 == DIR_STOP) |-> (duty7 == DUTY_STOP) && enc_rst7)
    else $error("stop result without stop duty or encoder reset");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (duty7 >= DUTY_STOP) && (duty7 <= DUTY_MAX))
    else $error("duty out of range");

  a_hist_shift: assert property (@(posedge clk) disable iff (rst)
    adv5 |=> (prev_prev_error == $past(prev_error)) && (prev_error == $past(e4)))
    else $error("error history did not shift");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");
`endif

endmodule
